>>> sv/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> sv/mdrp_pkg.sv
package mdrp_pkg;

   localparam int RECORD_BYTES = 16;
   localparam int RECORD_WORDS = RECORD_BYTES / 2;
   localparam int LEN_WIDTH = 9;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = 9'd511;
   localparam logic [LEN_WIDTH-1:0] HEADER_BYTES = 9'd3;
   localparam int EXC_BIT = 7;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GROUP_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_FUNCTION = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVER_COUNT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_DRIVER_ID = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_DRIVER_ID = 3'd4;

   localparam logic [7:0] GROUP_ADDRESS_RESET = 8'h65;
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FUNC_READ_WRITE = 8'h17;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_LENGTH    = 3'd1,
      STAT_EXCEPTION = 3'd2,
      STAT_ADDRESS   = 3'd3,
      STAT_FUNCTION  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIMPLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

endpackage

>>> sv/mdrp_ram.sv
module mdrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/multidrive_response_parser.sv
// Response frame parser for a group of motor drivers.
// The req channel carries one frame byte per transfer, with req_end_of_frame
// set on the last byte. A byte is taken every cycle; only a final byte waits
// while the results of the previous frame are still being read out.
// The rsp channel carries one result per transfer: an error or empty result
// (one transfer), or one decoded record for each of the first two drivers.
// An error result is loaded into the output register as the final byte is taken,
// or from ST_SIMPLE once a stalled output frees. A record takes eight reads of the
// registered record RAM in ST_FETCH, and ST_EMIT loads it once the last data is in.
// The record RAM holds two banks, so the next frame fills one bank while the
// previous frame is read from the other.
// The csr port writes the address, function code, driver count and two driver ids;
// the user must write it only while no frame is in progress; no check enforces it.
// Reset clears the frame count, the sequencer and the output valid and
// restores the register defaults; the RAM is not cleared.
// When the receiver stalls, the output register holds its result, reading
// stops before the next record is loaded, and non-final bytes are still taken.
module multidrive_response_parser #(
   parameter int MAX_RECORDS = 2
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [7:0]                              req_rx_byte,
   input  logic                                    req_end_of_frame,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [2:0]                              rsp_parse_status,
   output logic [3:0]                              rsp_record_driver,
   output logic [15:0]                             rsp_status_word,
   output logic [15:0]                             rsp_alarm_word,
   output logic signed [15:0]                      rsp_speed_rpm,
   output logic [15:0]                             rsp_bus_voltage,
   output logic [15:0]                             rsp_motor_current,
   output logic signed [31:0]                      rsp_position,
   output logic [15:0]                             rsp_check_word,
   output logic                                    rsp_last_result,
   input  logic                                    csr_write,
   input  logic [mdrp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mdrp_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int BUF_BYTES = MAX_RECORDS * mdrp_pkg::RECORD_BYTES;
   localparam int BANK_AW = $clog2(MAX_RECORDS * mdrp_pkg::RECORD_WORDS);
   localparam int RAM_DEPTH = 2 * (2 ** BANK_AW);
   localparam int RAM_AW = BANK_AW + 1;
   localparam int REC_LIMIT = (MAX_RECORDS < 2) ? MAX_RECORDS : 2;

   mdrp_pkg::state_type state_ff, state_in;

   logic [7:0] group_address_ff;
   logic [7:0] expected_function_ff;
   logic [3:0] driver_count_ff;
   logic [3:0] first_driver_id_ff;
   logic [3:0] second_driver_id_ff;

   logic [mdrp_pkg::LEN_WIDTH-1:0] frame_length_ff;
   logic [7:0] header_ff [3];
   logic [7:0] hi_byte_ff;
   logic       bank_ff;
   logic       pend_bank_ff;
   mdrp_pkg::status_type pend_code_ff;
   logic [1:0] nrec_ff;
   logic       rec_ff;
   logic [2:0] rd_cnt_ff;
   logic       rd_pend_ff;
   logic [2:0] rd_idx_ff;
   logic [15:0] words_ff [mdrp_pkg::RECORD_WORDS];
   logic       rsp_valid_ff;

   logic       in_take;
   logic       eof_take;
   logic       out_free;
   logic       load_simple;
   logic       load_record;
   logic       rd_en;
   logic       last_rec;
   logic       len_room;
   logic [mdrp_pkg::LEN_WIDTH-1:0] byte_off;
   logic       in_buffer;
   logic [mdrp_pkg::LEN_WIDTH-1:0] len_final;
   logic [mdrp_pkg::LEN_WIDTH-1:0] len_needed;
   logic [7:0] hdr_addr;
   logic [7:0] hdr_func;
   logic [7:0] hdr_count;
   mdrp_pkg::status_type chk_code;
   logic [1:0] chk_nrec;
   logic       chk_simple;
   logic       ram_wr_en;
   logic [RAM_AW-1:0] ram_wr_addr;
   logic [RAM_AW-1:0] ram_rd_addr;
   logic [15:0] ram_rd_data;

   assign in_take = req_valid && req_ready;
   assign eof_take = in_take && req_end_of_frame;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !(req_end_of_frame && (state_ff != mdrp_pkg::ST_IDLE));

   assign len_room = frame_length_ff < mdrp_pkg::LEN_MAX;
   assign byte_off = frame_length_ff - mdrp_pkg::HEADER_BYTES;
   assign in_buffer = (frame_length_ff >= mdrp_pkg::HEADER_BYTES) &&
                      (byte_off < mdrp_pkg::LEN_WIDTH'(BUF_BYTES));

   // Header as it stands once the current byte is included.
   assign hdr_addr  = (frame_length_ff == 9'd0) ? req_rx_byte : header_ff[0];
   assign hdr_func  = (frame_length_ff == 9'd1) ? req_rx_byte : header_ff[1];
   assign hdr_count = (frame_length_ff == 9'd2) ? req_rx_byte : header_ff[2];
   assign len_final = len_room ? frame_length_ff + 9'd1 : frame_length_ff;
   assign len_needed = {1'b0, driver_count_ff, 4'b0000} + mdrp_pkg::HEADER_BYTES;

   always_comb begin
      if (len_final < mdrp_pkg::HEADER_BYTES) begin
         chk_code = mdrp_pkg::STAT_LENGTH;
      end else if (hdr_func[mdrp_pkg::EXC_BIT]) begin
         chk_code = mdrp_pkg::STAT_EXCEPTION;
      end else if (hdr_addr != group_address_ff) begin
         chk_code = mdrp_pkg::STAT_ADDRESS;
      end else if (hdr_func != expected_function_ff) begin
         chk_code = mdrp_pkg::STAT_FUNCTION;
      end else if (hdr_count != {driver_count_ff, 4'b0000}) begin
         chk_code = mdrp_pkg::STAT_LENGTH;
      end else if (len_final < len_needed) begin
         chk_code = mdrp_pkg::STAT_LENGTH;
      end else begin
         chk_code = mdrp_pkg::STAT_OK;
      end
   end

   assign chk_nrec = (driver_count_ff < 4'(REC_LIMIT)) ? driver_count_ff[1:0] : 2'(REC_LIMIT);
   assign chk_simple = (chk_code != mdrp_pkg::STAT_OK) || (chk_nrec == 2'd0);
   assign last_rec = ({1'b0, rec_ff} + 2'd1) == nrec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdrp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      load_simple = 1'b0;
      load_record = 1'b0;
      rd_en = 1'b0;
      unique case (state_ff)
         mdrp_pkg::ST_IDLE: begin
            if (eof_take) begin
               if (!chk_simple) begin
                  state_in = mdrp_pkg::ST_FETCH;
               end else if (out_free) begin
                  load_simple = 1'b1;
               end else begin
                  state_in = mdrp_pkg::ST_SIMPLE;
               end
            end
         end
         mdrp_pkg::ST_SIMPLE: begin
            if (out_free) begin
               load_simple = 1'b1;
               state_in = mdrp_pkg::ST_IDLE;
            end
         end
         mdrp_pkg::ST_FETCH: begin
            rd_en = 1'b1;
            if (rd_cnt_ff == 3'd7) begin
               state_in = mdrp_pkg::ST_EMIT;
            end
         end
         mdrp_pkg::ST_EMIT: begin
            if (out_free && !rd_pend_ff) begin
               load_record = 1'b1;
               state_in = last_rec ? mdrp_pkg::ST_IDLE : mdrp_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = mdrp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_address_ff <= mdrp_pkg::GROUP_ADDRESS_RESET;
         expected_function_ff <= mdrp_pkg::FUNC_READ_HOLDING;
         driver_count_ff <= 4'd2;
         first_driver_id_ff <= 4'd1;
         second_driver_id_ff <= 4'd2;
         frame_length_ff <= '0;
         bank_ff <= 1'b0;
         rec_ff <= 1'b0;
         rd_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               mdrp_pkg::CSR_GROUP_ADDRESS:     group_address_ff <= csr_wdata;
               mdrp_pkg::CSR_EXPECTED_FUNCTION: expected_function_ff <= csr_wdata;
               mdrp_pkg::CSR_DRIVER_COUNT:      driver_count_ff <= csr_wdata[3:0];
               mdrp_pkg::CSR_FIRST_DRIVER_ID:   first_driver_id_ff <= csr_wdata[3:0];
               mdrp_pkg::CSR_SECOND_DRIVER_ID:  second_driver_id_ff <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
         if (eof_take) begin
            frame_length_ff <= '0;
            bank_ff <= ~bank_ff;
            rec_ff <= 1'b0;
            rd_cnt_ff <= '0;
         end else if (in_take && len_room) begin
            frame_length_ff <= frame_length_ff + 9'd1;
         end
         if (rd_en) begin
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
         end
         if (load_record) begin
            rec_ff <= ~rec_ff;
         end
         rd_pend_ff <= rd_en;
         if (load_simple || load_record) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && len_room) begin
         if (frame_length_ff < mdrp_pkg::HEADER_BYTES) begin
            header_ff[frame_length_ff[1:0]] <= req_rx_byte;
         end
         if (in_buffer && !byte_off[0]) begin
            hi_byte_ff <= req_rx_byte;
         end
      end
      if (eof_take) begin
         pend_code_ff <= chk_code;
         nrec_ff <= chk_nrec;
         pend_bank_ff <= bank_ff;
      end
      rd_idx_ff <= rd_cnt_ff;
      if (rd_pend_ff) begin
         words_ff[rd_idx_ff] <= ram_rd_data;
      end
      if (load_simple) begin
         rsp_parse_status <= (state_ff == mdrp_pkg::ST_IDLE) ? chk_code : pend_code_ff;
         rsp_record_driver <= '0;
         rsp_status_word <= '0;
         rsp_alarm_word <= '0;
         rsp_speed_rpm <= '0;
         rsp_bus_voltage <= '0;
         rsp_motor_current <= '0;
         rsp_position <= '0;
         rsp_check_word <= '0;
         rsp_last_result <= 1'b1;
      end else if (load_record) begin
         rsp_parse_status <= mdrp_pkg::STAT_OK;
         rsp_record_driver <= rec_ff ? second_driver_id_ff : first_driver_id_ff;
         rsp_status_word <= words_ff[0];
         rsp_alarm_word <= words_ff[1];
         rsp_speed_rpm <= $signed(words_ff[2]);
         rsp_bus_voltage <= words_ff[3];
         rsp_motor_current <= words_ff[4];
         rsp_position <= $signed({words_ff[5], words_ff[6]});
         rsp_check_word <= words_ff[7];
         rsp_last_result <= last_rec;
      end
   end

   // Bytes are paired into big-endian words; the odd byte of a pair writes the word.
   assign ram_wr_en = in_take && len_room && in_buffer && byte_off[0];
   assign ram_wr_addr = {bank_ff, byte_off[BANK_AW:1]};
   assign ram_rd_addr = {pend_bank_ff, BANK_AW'({rec_ff, rd_cnt_ff})};

   mdrp_ram #(
      .WIDTH(16),
      .DEPTH(RAM_DEPTH)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({hi_byte_ff, req_rx_byte}),
      .rd_en   (rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/mdrp_checker.sv
`include "assert_macros.svh"

module mdrp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_end_of_frame,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [2:0]                           rsp_parse_status,
   input logic [3:0]                           rsp_record_driver,
   input logic [15:0]                          rsp_status_word,
   input logic signed [31:0]                   rsp_position,
   input logic [15:0]                          rsp_check_word,
   input logic                                 rsp_last_result
);

   logic        err_shown;
   logic        err_clear;
   logic        data_clear;
   logic        rsp_ok;
   logic        stalled;
   logic [32:0] rsp_watch;

   assign err_shown = rsp_valid && (rsp_parse_status != mdrp_pkg::STAT_OK);
   assign err_clear = rsp_last_result && (rsp_record_driver == 4'd0) &&
                      (rsp_position == 32'sd0);
   assign data_clear = (rsp_status_word == 16'd0) && (rsp_check_word == 16'd0);
   assign rsp_ok = rsp_parse_status == mdrp_pkg::STAT_OK;
   assign stalled = rsp_valid && !rsp_ready;
   assign rsp_watch = {rsp_position, rsp_last_result};

   `ASSERT_SAME(a_error_is_final, clock, reset, err_shown, err_clear)
   `ASSERT_SAME(a_only_final_byte_waits, clock, reset, req_valid && !req_ready, req_end_of_frame)
   `ASSERT_SAME(a_record_is_ok, clock, reset, rsp_valid && !rsp_last_result, rsp_ok)
   `ASSERT_NEXT(a_stall_holds, clock, reset, stalled, rsp_valid && $stable(rsp_watch))
   `ASSERT_SAME(a_error_data_clear, clock, reset, err_shown, data_clear)

endmodule

bind multidrive_response_parser mdrp_checker u_mdrp_checker (.*);
